### hw/rtl/pss_pkg.sv
// Shared types and constants for the block prefix-sum scanner.
// No dependencies; imported by every module of the block but pss_ram.
package pss_pkg;

   // Storage and data sizing
   localparam int MAX_BLOCK  = 64;
   localparam int DATA_WIDTH = 32;
   localparam int INDEX_W    = $clog2(MAX_BLOCK);
   localparam int LOG_W      = 3;
   localparam int MAX_LOG2   = INDEX_W;

   // Block length code after reset (64 elements)
   localparam logic [LOG_W-1:0] LOG_RESET = LOG_W'(6);

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_READ = 3'b010,
      ST_SHOW = 3'b100
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_en;   // accept one element into the store
      logic emit_next; // current sum taken, step to the next entry
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic load_last; // current load index is the last of the block
      logic emit_last; // current read index is the last of the block
   } sts_type;

endpackage

### hw/rtl/block_prefix_sum_scan.sv
// Top level of the block inclusive prefix-sum scanner.
// Depends on pss_pkg, pss_ctrl and pss_dp (which holds pss_ram).
//
//   Port group   Direction  Handshake          Payload
//   req_         in         req_valid/stall    req_value (signed 32)
//   rsp_         out        rsp_valid/stall    rsp_sum (signed 32), rsp_last
//   csr_         in         csr_wr_en          csr_wr_data (block_log2, 3 bits)
//
// Elements load at one per cycle into a 64-entry store as running sums.
// After a block's last element, each sum is first read from the store, then
// presented with rsp_valid high.
// No input transaction is taken while the block's sums are being emitted.
// rsp_stall holds the current sum; reset is synchronous, block length 64.
module block_prefix_sum_scan
   import pss_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [LOG_W-1:0]             csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_sum,
   output logic                         rsp_last
);

   cmd_type cmd;
   sts_type sts;

   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pss_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_value   (req_value),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_sum     (rsp_sum),
      .rsp_last    (rsp_last)
   );

endmodule

### hw/rtl/pss_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read the addressed entry every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pss_dp.sv
// Datapath: length register, index counter, running accumulator and store.
// Depends on pss_pkg and pss_ram.
module pss_dp
   import pss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [LOG_W-1:0]      csr_wr_data,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic [DATA_WIDTH-1:0] rsp_sum,
   output logic                  rsp_last
);

   logic [LOG_W-1:0]      log2_ff,  log2_in;
   logic [INDEX_W-1:0]    idx_ff,   idx_in;
   logic [DATA_WIDTH-1:0] acc_ff,   acc_in;
   logic [LOG_W-1:0]      eff_log;
   logic [INDEX_W-1:0]    last_idx;
   logic                  at_last;
   logic [DATA_WIDTH-1:0] new_sum;

   // Clamp the length code to 1..MAX_LOG2 and form the last index
   always_comb begin
      eff_log = log2_ff;
      if (log2_ff == '0) begin
         eff_log = LOG_W'(1);
      end else if (log2_ff > LOG_W'(MAX_LOG2)) begin
         eff_log = LOG_W'(MAX_LOG2);
      end
   end

   assign last_idx = ~({INDEX_W{1'b1}} << eff_log);
   assign at_last  = (idx_ff == last_idx);
   assign new_sum  = acc_ff + req_value;

   // Next-state logic for counter, accumulator and length code
   always_comb begin
      log2_in = log2_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      if (csr_wr_en) begin
         log2_in = csr_wr_data;
         idx_in  = '0;
         acc_in  = '0;
      end else if (cmd.load_en) begin
         idx_in = at_last ? '0 : idx_ff + INDEX_W'(1);
         acc_in = at_last ? '0 : new_sum;
      end else if (cmd.emit_next) begin
         idx_in = at_last ? '0 : idx_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= LOG_RESET;
         idx_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         log2_ff <= log2_in;
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
      end
   end

   // Store holds running sums; read back in order during emission
   pss_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_BLOCK)
   ) u_store (
      .clock   (clock),
      .we      (cmd.load_en),
      .addr    (idx_ff),
      .wr_data (new_sum),
      .rd_data (rsp_sum)
   );

   assign sts.load_last = at_last;
   assign sts.emit_last = at_last;
   assign rsp_last      = at_last;

   // Counter and accumulator restart after a block's last element
   a_load_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en && at_last && !csr_wr_en |=> idx_ff == '0 && acc_ff == '0)
      else $error("index or accumulator not cleared after last element");

   // Counter never passes the block's last index
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      !csr_wr_en && $stable(log2_ff) && idx_ff <= last_idx |=> idx_ff <= last_idx)
      else $error("index beyond block length");

endmodule

### hw/rtl/pss_ctrl.sv
// Controller: sequences element loading and the in-order sum emission.
// Depends on pss_pkg.
module pss_ctrl
   import pss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // Handshake and commands
   assign req_stall     = (state_ff != ST_LOAD);
   assign rsp_valid     = (state_ff == ST_SHOW);
   assign cmd.load_en   = (state_ff == ST_LOAD) && req_valid;
   assign cmd.emit_next = (state_ff == ST_SHOW) && !rsp_stall;

   // State transitions
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (cmd.load_en && sts.load_last) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) state_in = sts.emit_last ? ST_LOAD : ST_READ;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Last element of a block starts emission
   a_start_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en && sts.load_last |=> state_ff == ST_READ)
      else $error("emission did not start after last element");

   // A RAM read is always followed by presenting its data
   a_read_show: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_SHOW)
      else $error("read not followed by presentation");

   // A stalled sum holds its place and its last flag
   a_show_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHOW && rsp_stall |=> state_ff == ST_SHOW && $stable(sts.emit_last))
      else $error("stalled transaction was dropped or changed");

endmodule

### tb/testbench.sv
// Self-checking testbench for block_prefix_sum_scan: a running-sum predictor
// checks every emitted prefix sum. Depends on pss_pkg and the block's RTL only.
module testbench;
   import pss_pkg::*;

   localparam int IDLE_PCT        = 18;
   localparam int RANDOM_ITEMS    = 220;
   localparam int SETTLE_CYCLES   = 12;
   localparam int PRESSURE_CYCLES = 250;
   localparam int CYCLE_LIMIT     = 200000;

   // One emitted result
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sum;
      logic                         last;
   } prefix_result_type;

   logic                         clock;
   logic                         reset       = 1'b1;
   logic                         csr_wr_en   = 1'b0;
   logic [LOG_W-1:0]             csr_wr_data = '0;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   logic signed [DATA_WIDTH-1:0] req_value   = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   logic signed [DATA_WIDTH-1:0] rsp_sum;
   logic                         rsp_last;

   // Predictor state
   logic [LOG_W-1:0]      model_log2 = LOG_RESET;
   int                    fill_count = 0;
   logic [DATA_WIDTH-1:0] block_vals [MAX_BLOCK];
   prefix_result_type     pending_sums [$];
   prefix_result_type     head_result;

   // Run control
   int               error_count = 0;
   int               cycle_count = 0;
   logic             quiet       = 1'b0;
   logic             hold_start  = 1'b0;
   int               hold_left   = 0;
   logic [LOG_W-1:0] sent_log2   = LOG_RESET;

   block_prefix_sum_scan dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sum     (rsp_sum),
      .rsp_last    (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("block_prefix_sum_scan test failed");
      $finish;
   end

   // Code 0 reads as 1; lengths above the store saturate
   function automatic int block_length_of(input logic [LOG_W-1:0] code);
      int lg;
      int len;
      lg  = (code < 1) ? 1 : int'(code);
      len = 1 << lg;
      if (len > MAX_BLOCK) len = MAX_BLOCK;
      return len;
   endfunction

   // Store one element; a full block yields its inclusive prefix sums
   function automatic void load_element(input logic [DATA_WIDTH-1:0] v);
      int                    n;
      logic [DATA_WIDTH-1:0] acc;
      prefix_result_type     r;
      n = block_length_of(model_log2);
      if (fill_count >= n) fill_count = 0;
      block_vals[fill_count] = v;
      fill_count++;
      if (fill_count == n) begin
         acc = '0;
         for (int k = 0; k < n; k++) begin
            acc    = acc + block_vals[k];
            r.sum  = acc;
            r.last = (k == n - 1);
            pending_sums.push_back(r);
         end
         fill_count = 0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Track accepted config writes and input transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            model_log2 = csr_wr_data;
            fill_count = 0;
         end
         if (req_valid && !req_stall) load_element(req_value);
      end
   end

   // Compare each result transaction with the oldest expected sum
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected sum %0d", rsp_sum));
         end else begin
            head_result = pending_sums.pop_front();
            if (rsp_sum !== head_result.sum)
               report_mismatch($sformatf("sum %0d, expected %0d",
                                         rsp_sum, $signed(head_result.sum)));
            if (rsp_last !== head_result.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_last, head_result.last));
         end
      end
   end

   // Result side: random stalls, quiet stretches and a long hold-off
   always @(posedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left  = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic logic [DATA_WIDTH-1:0] random_element();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return ($urandom_range(1) != 0) ? 32'h0 : 32'h1;
         default: return $urandom;
      endcase
   endfunction

   // Offer one element and hold it until the block takes it
   task automatic send_element(input logic [DATA_WIDTH-1:0] v);
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait out every pending sum, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_block_log2(input logic [LOG_W-1:0] code);
      wait_idle();
      sent_log2    = code;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_blocks(input int count);
      repeat (count * block_length_of(sent_log2)) send_element(random_element());
   endtask

   // Length after reset is 64
   task automatic test_reset_length();
      send_blocks(1);
   endtask

   // Two-element blocks, including code zero, with wrapping sums
   task automatic test_short_blocks();
      set_block_log2(LOG_W'(1));
      send_element(32'h7FFF_FFFF);
      send_element(32'h0000_0001);
      set_block_log2(LOG_W'(0));
      send_element(32'h8000_0000);
      send_element(32'h8000_0000);
   endtask

   // A config write drops a partly loaded block
   task automatic test_discard_partial();
      set_block_log2(LOG_W'(2));
      send_element(32'h1234_5678);
      send_element(32'h0000_0010);
      send_element(32'hFFFF_0000);
      set_block_log2(LOG_W'(2));
      repeat (4) send_element(32'hFFFF_FFFF);
   endtask

   task automatic test_extreme_values();
      set_block_log2(LOG_W'(3));
      send_element(32'h7FFF_FFFF);
      send_element(32'h0000_0001);
      send_element(32'h8000_0000);
      send_element(32'hFFFF_FFFF);
      send_element(32'h0000_0000);
      send_element(32'h5555_5555);
      send_element(32'hAAAA_AAAA);
      send_element(32'h8000_0000);
   endtask

   // Code 7 saturates at the store size
   task automatic test_length_saturation();
      set_block_log2(LOG_W'(7));
      send_blocks(1);
   endtask

   // Receiver holds off while the sender keeps offering
   task automatic test_pressure();
      set_block_log2(LOG_W'(3));
      hold_start = 1'b1;
      send_blocks(3);
   endtask

   task automatic test_back_to_back();
      set_block_log2(LOG_W'(2));
      quiet = 1'b1;
      send_blocks(6);
      wait_idle();
      quiet = 1'b0;
   endtask

   // Mostly short blocks of random content, some broken by a config write
   task automatic test_random_blocks();
      int               loaded;
      int               big_left;
      int               n;
      int               r;
      int               blocks;
      logic [LOG_W-1:0] code;
      loaded   = 0;
      big_left = 0;
      while (loaded < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 65)      code = LOG_W'($urandom_range(1, 3));
         else if (r < 78) code = LOG_W'(0);
         else if (r < 90) code = LOG_W'(4);
         else if (r < 96) code = LOG_W'(5);
         else             code = LOG_W'($urandom_range(6, 7));
         if (block_length_of(code) == MAX_BLOCK) begin
            if (big_left == 0) code = LOG_W'(2);
            else big_left--;
         end
         set_block_log2(code);
         n = block_length_of(code);
         if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, n - 1)) send_element(random_element());
            set_block_log2(code);
         end
         blocks = $urandom_range(1, 4);
         send_blocks(blocks);
         loaded += blocks * n;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_length();
      test_short_blocks();
      test_discard_partial();
      test_extreme_values();
      test_length_saturation();
      test_pressure();
      test_back_to_back();
      test_random_blocks();
      wait_idle();
      if (error_count == 0 && pending_sums.size() == 0) begin
         $display("block_prefix_sum_scan test passed");
      end else begin
         $display("block_prefix_sum_scan test failed");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/pss_pkg.sv
hw/rtl/pss_ram.sv
hw/rtl/pss_dp.sv
hw/rtl/pss_ctrl.sv
hw/rtl/block_prefix_sum_scan.sv
tb/testbench.sv
